>>> hw/rtl/rau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, constants and the magnitude function of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DIV = 2'd3;

  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_MUL_A,
    CMD_MUL_B,
    CMD_MUL_D,
    CMD_COMBINE,
    CMD_GCD_STEP,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_EMIT
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULA,
    S_MULB,
    S_MULD,
    S_COMB,
    S_GCD,
    S_DINIT,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic err;
    logic num_zero;
    logic gcd_done;
    logic div_last;
    logic out_free;
  } stat_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rau_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: steps the datapath through multiply, combine, GCD and divide.
// ----------------------------------------------------------------------------
module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MULA;
      S_MULA:  state_nxt = stat.err ? S_EMIT : S_MULB;
      S_MULB:  state_nxt = S_MULD;
      S_MULD:  state_nxt = S_COMB;
      S_COMB:  state_nxt = S_GCD;
      S_GCD: begin
        if (stat.num_zero) state_nxt = S_EMIT;
        else if (stat.gcd_done) state_nxt = S_DINIT;
      end
      S_DINIT: state_nxt = S_DIV;
      S_DIV:   if (stat.div_last) state_nxt = S_EMIT;
      S_EMIT:  if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = CMD_NOP;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd = CMD_LOAD;
      end
      S_MULA:  cmd = CMD_MUL_A;
      S_MULB:  cmd = CMD_MUL_B;
      S_MULD:  cmd = CMD_MUL_D;
      S_COMB:  cmd = CMD_COMBINE;
      S_GCD:   if (!stat.num_zero && !stat.gcd_done) cmd = CMD_GCD_STEP;
      S_DINIT: cmd = CMD_DIV_INIT;
      S_DIV:   cmd = CMD_DIV_STEP;
      S_EMIT:  if (stat.out_free) cmd = CMD_EMIT;
      default: cmd = CMD_NOP;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/rau_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: shared 32x32 multiplier, sign-magnitude add, binary GCD,
// two-lane restoring divider and the output register.
// ----------------------------------------------------------------------------
module rau_dp
  import rau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_a_num,
  input  wire logic [31:0] in_a_den,
  input  wire logic [31:0] in_b_num,
  input  wire logic [31:0] in_b_den,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_res_num,
  output logic [61:0]      out_res_den,
  output logic             out_zero_den_error
);

  logic [1:0]  func_r;
  logic [31:0] an_m_r, ad_m_r, bn_m_r, bd_m_r;
  logic        an_s_r, ad_s_r, bn_s_r, bd_s_r;
  logic        err_r;
  logic [63:0] pa_mag_r, pb_mag_r, num_mag_r, den_mag_r;
  logic        pa_neg_r, pb_neg_r, num_neg_r, den_neg_r;
  logic [63:0] gx_r, gy_r, g_r;
  logic [5:0]  k_r, cnt_r;
  logic [63:0] nq_r, dq_r;
  logic [64:0] nr_r, dr_r;
  logic        out_valid_r, out_err_r;
  logic [63:0] out_num_r;
  logic [61:0] out_den_r;

  logic [31:0] mx, my;
  logic        sx, sy;
  logic [63:0] mp;
  logic        mneg;

  always_comb begin
    mx = an_m_r;
    sx = an_s_r;
    my = bd_m_r;
    sy = bd_s_r;
    case (cmd)
      CMD_MUL_A: begin
        if (func_r == FUNC_MUL) begin
          my = bn_m_r;
          sy = bn_s_r;
        end
      end
      CMD_MUL_B: begin
        mx = bn_m_r;
        sx = bn_s_r;
        my = ad_m_r;
        sy = ad_s_r;
      end
      CMD_MUL_D: begin
        mx = ad_m_r;
        sx = ad_s_r;
        if (func_r == FUNC_DIV) begin
          my = bn_m_r;
          sy = bn_s_r;
        end
      end
      default: ;
    endcase
  end

  assign mp   = 64'(mx) * 64'(my);
  assign mneg = (sx ^ sy) && (mp != 64'd0);

  logic        tneg, c_neg;
  logic [63:0] c_mag;

  always_comb begin
    tneg = (func_r == FUNC_SUB) ? ((pb_mag_r != 64'd0) && !pb_neg_r) : pb_neg_r;
    if (func_r == FUNC_MUL || func_r == FUNC_DIV) begin
      c_mag = pa_mag_r;
      c_neg = pa_neg_r;
    end else if (pa_neg_r == tneg) begin
      c_mag = pa_mag_r + pb_mag_r;
      c_neg = pa_neg_r;
    end else if (pa_mag_r >= pb_mag_r) begin
      c_mag = pa_mag_r - pb_mag_r;
      c_neg = pa_neg_r;
    end else begin
      c_mag = pb_mag_r - pa_mag_r;
      c_neg = tneg;
    end
    if (c_mag == 64'd0) c_neg = 1'b0;
  end

  logic [64:0] nrs, drs, nrd, drd;
  logic        nbit, dbit;

  assign nrs  = {nr_r[63:0], nq_r[63]};
  assign drs  = {dr_r[63:0], dq_r[63]};
  assign nrd  = nrs - {1'b0, g_r};
  assign drd  = drs - {1'b0, g_r};
  assign nbit = !nrd[64];
  assign dbit = !drd[64];

  logic        res_neg, ovf, out_free;
  logic [63:0] res_num;

  assign res_neg  = num_neg_r ^ den_neg_r;
  assign ovf      = dq_r[63] || dq_r[62] || (!res_neg && nq_r[63]);
  assign res_num  = res_neg ? (~nq_r + 64'd1) : nq_r;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        func_r <= in_func;
        an_m_r <= mag32(in_a_num);
        ad_m_r <= mag32(in_a_den);
        bn_m_r <= mag32(in_b_num);
        bd_m_r <= mag32(in_b_den);
        an_s_r <= in_a_num[31];
        ad_s_r <= in_a_den[31];
        bn_s_r <= in_b_num[31];
        bd_s_r <= in_b_den[31];
        err_r  <= (in_a_den == 32'd0) || (in_b_den == 32'd0) ||
                  ((in_func == FUNC_DIV) && (in_b_num == 32'd0));
        k_r    <= '0;
      end
      CMD_MUL_A: begin
        pa_mag_r <= mp;
        pa_neg_r <= mneg;
      end
      CMD_MUL_B: begin
        pb_mag_r <= mp;
        pb_neg_r <= mneg;
      end
      CMD_MUL_D: begin
        den_mag_r <= mp;
        den_neg_r <= mneg;
        gy_r      <= mp;
      end
      CMD_COMBINE: begin
        num_mag_r <= c_mag;
        num_neg_r <= c_neg;
        gx_r      <= c_mag;
      end
      CMD_GCD_STEP: begin
        if (!gx_r[0] && !gy_r[0]) begin
          gx_r <= gx_r >> 1;
          gy_r <= gy_r >> 1;
          k_r  <= k_r + 6'd1;
        end else if (!gx_r[0]) begin
          gx_r <= gx_r >> 1;
        end else if (!gy_r[0]) begin
          gy_r <= gy_r >> 1;
        end else if (gx_r > gy_r) begin
          gx_r <= gx_r - gy_r;
        end else begin
          gy_r <= gy_r - gx_r;
        end
      end
      CMD_DIV_INIT: begin
        g_r   <= gx_r << k_r;
        nq_r  <= num_mag_r;
        dq_r  <= den_mag_r;
        nr_r  <= '0;
        dr_r  <= '0;
        cnt_r <= '0;
      end
      CMD_DIV_STEP: begin
        nr_r  <= nbit ? nrd : nrs;
        dr_r  <= dbit ? drd : drs;
        nq_r  <= {nq_r[62:0], nbit};
        dq_r  <= {dq_r[62:0], dbit};
        cnt_r <= cnt_r + 6'd1;
      end
      CMD_EMIT: begin
        if (err_r || (num_mag_r != 64'd0 && ovf)) begin
          out_num_r <= '0;
          out_den_r <= 62'd1;
          out_err_r <= 1'b1;
        end else if (num_mag_r == 64'd0) begin
          out_num_r <= '0;
          out_den_r <= 62'd1;
          out_err_r <= 1'b0;
        end else begin
          out_num_r <= res_num;
          out_den_r <= dq_r[61:0];
          out_err_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == CMD_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.err      = err_r;
  assign stat.num_zero = (num_mag_r == 64'd0);
  assign stat.gcd_done = (gx_r == gy_r);
  assign stat.div_last = (cnt_r == 6'd63);
  assign stat.out_free = out_free;

  assign out_valid          = out_valid_r;
  assign out_res_num        = out_num_r;
  assign out_res_den        = out_den_r;
  assign out_zero_den_error = out_err_r;

`ifndef SYNTHESIS
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_GCD_STEP |-> gx_r != 64'd0 && gy_r != 64'd0)
    else $error("gcd step on zero operand");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_EMIT |-> out_free)
    else $error("emit into occupied output register");
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_den_r != 62'd0)
    else $error("zero result denominator");
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_num_r == 64'd0 && out_den_r == 62'd1)
    else $error("error result not 0/1");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/rational_arithmetic_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two 32-bit fractions and returns
// the result reduced by its greatest common divisor.
//
// Input channel: in_func, in_a_num, in_a_den, in_b_num, in_b_den move on a
// transfer (in_valid high, in_stall low). One item is in work at a time;
// in_stall is low only while the sequencer is idle.
// Output channel: out_res_num, out_res_den, out_zero_den_error move on a
// transfer (out_valid high, out_stall low), one result per item. The result
// sits in an output register, so a new item is taken while it waits.
// Steps: an item with a zero denominator (or a zero divisor) goes from the
// first multiply straight to emit; one with a zero numerator goes from the
// multiplies and combine to emit; otherwise the sequencer multiplies and
// combines, runs the binary GCD, sets up and runs the bit-serial divider
// that reduces numerator and denominator together, and emits.
// A stalled receiver holds the result; the next result waits in the
// sequencer until the output register is free.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties
// the output register.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [31:0] in_a_num,
  input  wire logic [31:0] in_a_den,
  input  wire logic [31:0] in_b_num,
  input  wire logic [31:0] in_b_den,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_res_num,
  output logic [61:0]      out_res_den,
  output logic             out_zero_den_error
);

  cmd_t  cmd;
  stat_t stat;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rau_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_func            (in_func),
    .in_a_num           (in_a_num),
    .in_a_den           (in_a_den),
    .in_b_num           (in_b_num),
    .in_b_den           (in_b_den),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_res_num        (out_res_num),
    .out_res_den        (out_res_den),
    .out_zero_den_error (out_zero_den_error)
  );

endmodule
`default_nettype wire
